>>> rtl/core/ddbst_pkg.sv
// ----------------------------------------------------------------------------
// ddbst_pkg
// Shared types and constants of the download-data-block section tracker.
// ----------------------------------------------------------------------------
package ddbst_pkg;

	// section header constants
	localparam logic [7:0]  TABLE_ID    = 8'h3C;
	localparam logic [7:0]  LEN_HI_MASK = 8'h0F;
	localparam logic [11:0] HEADER_LEN  = 12'd30;
	localparam logic [12:0] MIN_SECTION = 13'd34;
	localparam logic [12:0] COUNT_MAX   = 13'd8191;

	// bitmap row geometry (row index field wide enough for the largest bitmap)
	localparam int WORD_BITS  = 16;
	localparam int WORD_IDX_W = 4;
	localparam int ROW_MAX_W  = 12;

	// result status codes
	typedef enum logic [2:0] {
		ST_COMPLETE = 3'd0,
		ST_MORE     = 3'd1,
		ST_IGNORED  = 3'd2,
		ST_VERSION  = 3'd3,
		ST_NOMEM    = 3'd4
	} status_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_GROUP   = 2'd0,
		CFG_MODULE  = 2'd1,
		CFG_VERSION = 2'd2
	} cfg_idx_t;

	// fields of one finished section, as captured
	typedef struct packed {
		logic [12:0] total;
		logic        table_ok;
		logic [11:0] decl_len;
		logic [31:0] crc;
		logic [7:0]  module_id;
		logic [7:0]  group_id;
		logic [15:0] version;
		logic [15:0] block;
		logic [15:0] blocks_total;
	} sect_t;

	// pre-evaluated checks of one section, ahead of the bitmap lookup
	typedef struct packed {
		logic        hdr_ok;
		logic        ver_ok;
		logic        too_many;
		logic        blk_lt_total;
		logic        blk_in;
		logic        plen_ok;
		logic [11:0] plen;
		logic [11:0] plen_m1;
		logic [23:0] offset;
		logic [15:0] block;
		logic [15:0] blocks_total;
	} cand_t;

	// bitmap read request
	typedef struct packed {
		logic                 en;
		logic [ROW_MAX_W-1:0] row;
	} bm_rd_t;

	// bitmap write request
	typedef struct packed {
		logic                 en;
		logic [ROW_MAX_W-1:0] row;
		logic [WORD_BITS-1:0] data;
	} bm_wr_t;

endpackage

>>> rtl/core/ddbst_capture.sv
// ----------------------------------------------------------------------------
// ddbst_capture
// Per-byte front end: CRC-32/MPEG-2, byte count and header field capture.
// Hands each finished section to the first pipeline register.
// ----------------------------------------------------------------------------
module ddbst_capture (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         section_byte,
	input  logic               last_byte,
	input  logic               take,
	output logic               sect_valid,
	output ddbst_pkg::sect_t   sect
);

	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

	// header byte positions
	localparam logic [12:0] POS_TABLE  = 13'd0;
	localparam logic [12:0] POS_LEN_HI = 13'd1;
	localparam logic [12:0] POS_LEN_LO = 13'd2;
	localparam logic [12:0] POS_MODULE = 13'd4;
	localparam logic [12:0] POS_BLK_HI = 13'd6;
	localparam logic [12:0] POS_BLK_LO = 13'd7;
	localparam logic [12:0] POS_GROUP  = 13'd12;
	localparam logic [12:0] POS_VER_HI = 13'd14;
	localparam logic [12:0] POS_VER_LO = 13'd15;
	localparam logic [12:0] POS_TOT_HI = 13'd28;
	localparam logic [12:0] POS_TOT_LO = 13'd29;

	// one byte through the MSB-first CRC register
	function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h0};
		for (int i = 0; i < 8; i++) begin
			c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	ddbst_pkg::sect_t cur_q;
	ddbst_pkg::sect_t nxt;
	ddbst_pkg::sect_t sect_s1;
	logic             sect_v_s1;

	// next section state with this byte folded in
	always_comb begin
		nxt = cur_q;
		nxt.crc = crc_step(cur_q.crc, section_byte);
		nxt.total = (cur_q.total != ddbst_pkg::COUNT_MAX) ? cur_q.total + 13'd1 : cur_q.total;
		case (cur_q.total)
			POS_TABLE:  nxt.table_ok = (section_byte == ddbst_pkg::TABLE_ID);
			POS_LEN_HI: nxt.decl_len[11:8] = section_byte[3:0] & ddbst_pkg::LEN_HI_MASK[3:0];
			POS_LEN_LO: nxt.decl_len[7:0] = section_byte;
			POS_MODULE: nxt.module_id = section_byte;
			POS_BLK_HI: nxt.block[15:8] = section_byte;
			POS_BLK_LO: nxt.block[7:0] = section_byte;
			POS_GROUP:  nxt.group_id = section_byte;
			POS_VER_HI: nxt.version[15:8] = section_byte;
			POS_VER_LO: nxt.version[7:0] = section_byte;
			POS_TOT_HI: nxt.blocks_total[15:8] = section_byte;
			POS_TOT_LO: nxt.blocks_total[7:0] = section_byte;
			default:    ;
		endcase
	end

	// running section state, cleared after every last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			cur_q.crc <= '1;
		end else if (accept) begin
			if (last_byte) begin
				cur_q     <= '0;
				cur_q.crc <= '1;
			end else begin
				cur_q <= nxt;
			end
		end
	end

	// first pipeline register: one finished section
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sect_v_s1 <= 1'b0;
		end else if (accept && last_byte) begin
			sect_v_s1 <= 1'b1;
		end else if (take) begin
			sect_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			sect_s1 <= nxt;
		end
	end

	assign sect_valid = sect_v_s1;
	assign sect       = sect_s1;

endmodule

>>> rtl/core/ddbst_bitmap.sv
// ----------------------------------------------------------------------------
// ddbst_bitmap
// Block-seen bitmap in a single-port-write, registered-read memory of 16-bit
// rows, with a clearing pass after reset and write-to-read forwarding.
// ----------------------------------------------------------------------------
module ddbst_bitmap #(
	parameter int MAX_BLOCKS = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ddbst_pkg::bm_rd_t                    rd,
	input  ddbst_pkg::bm_wr_t                    wr,
	output logic [ddbst_pkg::WORD_BITS-1:0]      row_data,
	output logic                                 busy
);

	localparam int ROWS  = (MAX_BLOCKS + ddbst_pkg::WORD_BITS - 1) / ddbst_pkg::WORD_BITS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	logic [ddbst_pkg::WORD_BITS-1:0] mem_q [ROWS];
	logic [ddbst_pkg::WORD_BITS-1:0] rdata_q;
	logic [ddbst_pkg::WORD_BITS-1:0] fwd_data_q;
	logic                            fwd_q;
	logic                            busy_q;
	logic [ROW_W-1:0]                clr_row_q;
	logic                            we;
	logic [ROW_W-1:0]                wa;
	logic [ddbst_pkg::WORD_BITS-1:0] wd;
	logic [ROW_W-1:0]                ra;

	// clearing pass owns the write port until done
	always_comb begin
		we = busy_q || wr.en;
		wa = busy_q ? clr_row_q : wr.row[ROW_W-1:0];
		wd = busy_q ? '0 : wr.data;
		ra = rd.row[ROW_W-1:0];
	end

	// memory array, read-first
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (rd.en) begin
			rdata_q <= mem_q[ra];
		end
	end

	// forward a row written at the same edge it was read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd.en) begin
			fwd_q <= wr.en && (wr.row[ROW_W-1:0] == ra);
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			fwd_data_q <= wr.data;
		end
	end

	// clear sweep, one row per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_row_q <= '0;
		end else if (busy_q) begin
			clr_row_q <= clr_row_q + ROW_W'(1);
			if (clr_row_q == LAST_ROW) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign row_data = fwd_q ? fwd_data_q : rdata_q;
	assign busy     = busy_q;

endmodule

>>> rtl/core/data_block_section_tracker.sv
// ----------------------------------------------------------------------------
// data_block_section_tracker
// Reassembly bookkeeping for download-data-block sections: CRC and header
// checks per section, block bitmap, block count and stored payload size.
// ----------------------------------------------------------------------------
// Takes one section byte per cycle while section_stall is low, with no gaps
// between sections. Each last byte gives one result via the capture register,
// check register and output register; results can leave one per cycle while
// result_stall is low. After reset the block bitmap is swept clear one 16-bit
// row per cycle over ceil(MAX_BLOCKS/16) rows (256 at the default), with
// section_stall held high meanwhile; configuration writes are taken during
// the sweep. The bitmap row is read as a section enters the check stage and
// written back as its result is loaded, so each stored section costs one read-modify-write.
module data_block_section_tracker #(
	parameter int MAX_BLOCKS   = 4096,
	parameter int BLOCK_STRIDE = 4062
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// section bytes
	input  logic        section_valid,
	output logic        section_stall,
	input  logic [7:0]  section_byte,
	input  logic        last_byte,
	// results
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic [15:0] block_number,
	output logic [23:0] buffer_offset,
	output logic [11:0] payload_bytes,
	output logic [12:0] blocks_done,
	output logic [23:0] total_size
);

	localparam int LIM_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [16:0] MAX_BLK = 17'(MAX_BLOCKS);
	localparam logic [12:0] STRIDE  = 13'(BLOCK_STRIDE);

	logic [7:0]  exp_group_q;
	logic [7:0]  exp_module_q;
	logic [15:0] exp_version_q;

	logic             accept;
	logic             s1_valid;
	ddbst_pkg::sect_t s1;
	logic             s1_take;
	logic             s1_ready;
	logic             s2_ready;
	logic             s2_take;
	logic             out_ready;
	logic             clr_busy;

	ddbst_pkg::cand_t cand;
	ddbst_pkg::cand_t cand_s2;
	logic             cand_v_s2;
	logic [28:0]      prod;

	ddbst_pkg::bm_rd_t               bm_rd;
	ddbst_pkg::bm_wr_t               bm_wr;
	logic [ddbst_pkg::WORD_BITS-1:0] bm_row;

	logic             total_known_q;
	logic [LIM_W-1:0] block_limit_q;
	logic [12:0]      stored_count_q;
	logic [23:0]      stored_size_q;

	logic               known_n;
	logic [LIM_W-1:0]   limit_n;
	logic [12:0]        count_n;
	logic [23:0]        size_n;
	logic               store;
	ddbst_pkg::status_t st_n;
	logic [16:0]        tot17;
	logic               seen;

	logic               out_v_q;
	ddbst_pkg::status_t status_q;
	logic [15:0]        block_q;
	logic [23:0]        offset_q;
	logic [11:0]        plen_q;
	logic [12:0]        done_q;
	logic [23:0]        size_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_group_q   <= '0;
			exp_module_q  <= '0;
			exp_version_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				ddbst_pkg::CFG_GROUP:   exp_group_q   <= cfg_data[7:0];
				ddbst_pkg::CFG_MODULE:  exp_module_q  <= cfg_data[7:0];
				ddbst_pkg::CFG_VERSION: exp_version_q <= cfg_data;
				default:                ;
			endcase
		end
	end

	// pipeline flow control
	assign out_ready     = !out_v_q || !result_stall;
	assign s2_ready      = !cand_v_s2 || out_ready;
	assign s2_take       = cand_v_s2 && out_ready;
	assign s1_ready      = !s1_valid || s2_ready;
	assign s1_take       = s1_valid && s2_ready;
	assign section_stall = clr_busy || !s1_ready;
	assign accept        = section_valid && !section_stall;

	ddbst_capture u_capture (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.section_byte (section_byte),
		.last_byte    (last_byte),
		.take         (s1_take),
		.sect_valid   (s1_valid),
		.sect         (s1)
	);

	// header, length, CRC, id and version checks; block range and payload length; buffer offset
	always_comb begin
		prod = {13'd0, s1.block} * {16'd0, STRIDE};
		cand.hdr_ok = (s1.total >= ddbst_pkg::MIN_SECTION) && s1.table_ok
			&& ({1'b0, s1.decl_len} + 13'd3 == s1.total) && (s1.crc == 32'd0)
			&& (s1.group_id == exp_group_q) && (s1.module_id == exp_module_q);
		cand.ver_ok       = (s1.version == exp_version_q);
		cand.too_many     = ({1'b0, s1.blocks_total} > MAX_BLK);
		cand.blk_lt_total = (s1.block < s1.blocks_total);
		cand.blk_in       = ({1'b0, s1.block} < MAX_BLK);
		cand.plen_ok      = (s1.decl_len > ddbst_pkg::HEADER_LEN + 12'd1);
		cand.plen         = s1.decl_len - (ddbst_pkg::HEADER_LEN + 12'd1);
		cand.plen_m1      = s1.decl_len - (ddbst_pkg::HEADER_LEN + 12'd2);
		cand.offset       = prod[23:0];
		cand.block        = s1.block;
		cand.blocks_total = s1.blocks_total;
	end

	// bitmap row read as the section enters the check stage
	always_comb begin
		bm_rd.en  = s1_take && cand.blk_in;
		bm_rd.row = s1.block[ddbst_pkg::WORD_IDX_W +: ddbst_pkg::ROW_MAX_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_v_s2 <= 1'b0;
		end else if (s1_take) begin
			cand_v_s2 <= 1'b1;
		end else if (s2_take) begin
			cand_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			cand_s2 <= cand;
		end
	end

	ddbst_bitmap #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_bitmap (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd       (bm_rd),
		.wr       (bm_wr),
		.row_data (bm_row),
		.busy     (clr_busy)
	);

	// allocation, range, duplicate and store decision
	always_comb begin
		known_n = total_known_q;
		limit_n = block_limit_q;
		count_n = stored_count_q;
		size_n  = stored_size_q;
		store   = 1'b0;
		st_n    = ddbst_pkg::ST_IGNORED;
		tot17   = {1'b0, cand_s2.blocks_total};
		seen    = bm_row[cand_s2.block[ddbst_pkg::WORD_IDX_W-1:0]];
		priority if (!cand_s2.hdr_ok) begin
			st_n = ddbst_pkg::ST_IGNORED;
		end else if (!cand_s2.ver_ok) begin
			st_n = ddbst_pkg::ST_VERSION;
		end else if (!total_known_q && cand_s2.too_many) begin
			st_n = ddbst_pkg::ST_NOMEM;
		end else begin
			// first accepted section fixes the limit
			if (!total_known_q) begin
				known_n = 1'b1;
				limit_n = tot17[LIM_W-1:0];
				count_n = '0;
			end
			if (cand_s2.blk_lt_total && !(tot17 > 17'(limit_n)) && cand_s2.blk_in
					&& !seen && cand_s2.plen_ok) begin
				store   = 1'b1;
				count_n = count_n + 13'd1;
				if (17'(count_n) == 17'(limit_n)) begin
					st_n   = ddbst_pkg::ST_COMPLETE;
					size_n = stored_size_q + {12'd0, cand_s2.plen_m1};
				end else begin
					st_n   = ddbst_pkg::ST_MORE;
					size_n = stored_size_q + {12'd0, cand_s2.plen};
				end
			end
		end
	end

	// bitmap write-back of the stored block
	always_comb begin
		bm_wr.en   = s2_take && store;
		bm_wr.row  = cand_s2.block[ddbst_pkg::WORD_IDX_W +: ddbst_pkg::ROW_MAX_W];
		bm_wr.data = bm_row
			| (ddbst_pkg::WORD_BITS'(1) << cand_s2.block[ddbst_pkg::WORD_IDX_W-1:0]);
	end

	// download state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_known_q  <= 1'b0;
			block_limit_q  <= '0;
			stored_count_q <= '0;
			stored_size_q  <= '0;
		end else if (s2_take) begin
			total_known_q  <= known_n;
			block_limit_q  <= limit_n;
			stored_count_q <= count_n;
			stored_size_q  <= size_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s2_take) begin
			out_v_q <= 1'b1;
		end else if (!result_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take) begin
			status_q <= st_n;
			block_q  <= store ? cand_s2.block : 16'd0;
			offset_q <= store ? cand_s2.offset : 24'd0;
			plen_q   <= store ? cand_s2.plen : 12'd0;
			done_q   <= count_n;
			size_q   <= size_n;
		end
	end

	assign result_valid  = out_v_q;
	assign status        = status_q;
	assign block_number  = block_q;
	assign buffer_offset = offset_q;
	assign payload_bytes = plen_q;
	assign blocks_done   = done_q;
	assign total_size    = size_q;

	// no bitmap store while the clearing sweep runs
	a_no_store_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		bm_wr.en |-> !clr_busy)
		else $error("bitmap store during clear sweep");

	// nothing is stored before the block limit is known
	a_empty_until_known: assert property (@(posedge clk) disable iff (!arst_n)
		!total_known_q |-> (stored_count_q == 13'd0) && (stored_size_q == 24'd0))
		else $error("stored state without known block limit");

	// stored count never passes the limit
	a_count_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		total_known_q |-> (17'(stored_count_q) <= 17'(block_limit_q)))
		else $error("stored count above block limit");

	// a stored block always carries payload
	a_store_has_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && ((status_q == ddbst_pkg::ST_COMPLETE) || (status_q == ddbst_pkg::ST_MORE))
		|-> (plen_q != 12'd0))
		else $error("stored result with empty payload");

endmodule

>>> test/data_block_section_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// data_block_section_tracker_tb
// Feeds download-data-block sections byte by byte into the tracker and checks
// every result against a cycle-free bookkeeping model held in the bench:
// header, length, CRC, id and version rejects, block allocation, duplicates,
// block range, completion, output back-pressure and register changes.
// ----------------------------------------------------------------------------
module data_block_section_tracker_tb;

	import ddbst_pkg::*;

	localparam int MAX_BLOCKS   = 4096;
	localparam int BLOCK_STRIDE = 4062;
	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
	localparam int HOLD_CYCLES  = 300;

	// expected outcome of one finished section
	typedef struct packed {
		status_t     st;
		logic [15:0] blk;
		logic [23:0] off;
		logic [11:0] plen;
		logic [12:0] done;
		logic [23:0] size;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        section_valid;
	logic        section_stall;
	logic [7:0]  section_byte;
	logic        last_byte;
	logic        result_valid;
	logic        result_stall;
	logic [2:0]  status;
	logic [15:0] block_number;
	logic [23:0] buffer_offset;
	logic [11:0] payload_bytes;
	logic [12:0] blocks_done;
	logic [23:0] total_size;

	data_block_section_tracker #(
		.MAX_BLOCKS  (MAX_BLOCKS),
		.BLOCK_STRIDE(BLOCK_STRIDE)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.section_valid(section_valid),
		.section_stall(section_stall),
		.section_byte (section_byte),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.block_number (block_number),
		.buffer_offset(buffer_offset),
		.payload_bytes(payload_bytes),
		.blocks_done  (blocks_done),
		.total_size   (total_size)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// bench-side copy of the registers
	logic [7:0]  reg_group;
	logic [7:0]  reg_module;
	logic [15:0] reg_version;

	// per-section capture
	logic [12:0] sec_count;
	logic [31:0] sec_crc;
	logic        sec_tid_ok;
	logic [11:0] sec_len;
	logic [7:0]  sec_module;
	logic [7:0]  sec_group;
	logic [15:0] sec_version;
	logic [15:0] sec_block;
	logic [15:0] sec_nblocks;

	// per-download bookkeeping
	logic        dl_known;
	logic [12:0] dl_limit;
	logic [12:0] dl_stored;
	logic [23:0] dl_size;
	logic        dl_have [0:MAX_BLOCKS-1];

	verdict_t    verdict_q[$];
	logic [7:0]  sect_buf[$];
	int          pick_pool[$];

	int err_cnt     = 0;
	int checked_cnt = 0;
	int sect_cnt    = 0;
	int byte_cnt    = 0;
	int cfg_sets    = 0;
	int hold_left   = 0;
	int dl_target;
	bit calm        = 1'b0;

	// ------------------------------------------------------------------------
	// bookkeeping model
	// ------------------------------------------------------------------------

	function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
		logic [31:0] r;
		int i;
		r = c ^ {b, 24'h0};
		for (i = 0; i < 8; i++)
			r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		return r;
	endfunction

	task automatic clear_capture();
		sec_count   = '0;
		sec_crc     = 32'hFFFF_FFFF;
		sec_tid_ok  = 1'b0;
		sec_len     = '0;
		sec_module  = '0;
		sec_group   = '0;
		sec_version = '0;
		sec_block   = '0;
		sec_nblocks = '0;
	endtask

	task automatic reset_model();
		int i;
		reg_group   = '0;
		reg_module  = '0;
		reg_version = '0;
		clear_capture();
		dl_known  = 1'b0;
		dl_limit  = '0;
		dl_stored = '0;
		dl_size   = '0;
		for (i = 0; i < MAX_BLOCKS; i++) dl_have[i] = 1'b0;
	endtask

	// grade a finished section and update the download state
	task automatic grade_section(output verdict_t v);
		status_t     st;
		logic [11:0] plen;
		logic [31:0] prod;
		int          i;
		plen = '0;
		if (sec_count < MIN_SECTION || !sec_tid_ok || sec_len + 12'd3 != sec_count ||
				sec_crc != 32'h0 || sec_group != reg_group || sec_module != reg_module)
			st = ST_IGNORED;
		else if (sec_version != reg_version)
			st = ST_VERSION;
		else if (!dl_known && sec_nblocks > MAX_BLOCKS)
			st = ST_NOMEM;
		else begin
			if (!dl_known) begin
				for (i = 0; i < MAX_BLOCKS; i++) dl_have[i] = 1'b0;
				dl_known  = 1'b1;
				dl_limit  = sec_nblocks[12:0];
				dl_stored = '0;
			end
			if (sec_block >= sec_nblocks || sec_nblocks > dl_limit ||
					sec_block >= MAX_BLOCKS || dl_have[sec_block] ||
					sec_len <= HEADER_LEN + 12'd1)
				st = ST_IGNORED;
			else begin
				plen = sec_len - (HEADER_LEN + 12'd1);
				dl_have[sec_block] = 1'b1;
				dl_stored = dl_stored + 13'd1;
				dl_size   = dl_size + plen;
				if (dl_stored == dl_limit) begin
					dl_size = dl_size - 24'd1;
					st = ST_COMPLETE;
				end else
					st = ST_MORE;
			end
		end
		prod   = sec_block * BLOCK_STRIDE;
		v.st   = st;
		v.blk  = (st == ST_COMPLETE || st == ST_MORE) ? sec_block : 16'h0;
		v.off  = (st == ST_COMPLETE || st == ST_MORE) ? prod[23:0] : 24'h0;
		v.plen = plen;
		v.done = dl_stored;
		v.size = dl_size;
	endtask

	// fold one accepted byte into the model
	task automatic track_byte(logic [7:0] b, logic last);
		verdict_t v;
		case (sec_count)
			13'd0:  sec_tid_ok = (b == TABLE_ID);
			13'd1:  sec_len[11:8] = b[3:0];
			13'd2:  sec_len[7:0] = b;
			13'd4:  sec_module = b;
			13'd6:  sec_block[15:8] = b;
			13'd7:  sec_block[7:0] = b;
			13'd12: sec_group = b;
			13'd14: sec_version[15:8] = b;
			13'd15: sec_version[7:0] = b;
			13'd28: sec_nblocks[15:8] = b;
			13'd29: sec_nblocks[7:0] = b;
			default: ;
		endcase
		sec_crc = crc_next(sec_crc, b);
		if (sec_count < COUNT_MAX) sec_count = sec_count + 13'd1;
		if (last) begin
			grade_section(v);
			verdict_q.push_back(v);
			clear_capture();
		end
	endtask

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int idle_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 15);
		if (r < 9) return 0;
		if (r < 14) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_byte(logic [7:0] b, logic last);
		int gap;
		int k;
		@(negedge clk);
		section_valid <= 1'b1;
		section_byte  <= b;
		last_byte     <= last;
		@(posedge clk);
		while (section_stall) @(posedge clk);
		byte_cnt++;
		track_byte(b, last);
		gap = idle_len();
		for (k = 0; k < gap; k++) begin
			@(negedge clk);
			section_valid <= 1'b0;
			section_byte  <= 8'($urandom);
		end
	endtask

	task automatic send_section();
		int i;
		for (i = 0; i < sect_buf.size(); i++)
			send_byte(sect_buf[i], i == sect_buf.size() - 1);
		sect_cnt++;
	endtask

	// header and payload, no CRC yet; payload length plen gives plen+34 bytes once sealed
	task automatic build_section(logic [7:0] grp, logic [7:0] mdl, logic [15:0] ver,
			logic [15:0] blk, logic [15:0] nblk, int plen);
		logic [11:0] dlen;
		logic [7:0]  b;
		int          i;
		dlen = 12'(plen + 31);
		sect_buf.delete();
		for (i = 0; i < 30; i++) begin
			b = 8'($urandom);
			case (i)
				0:  b = TABLE_ID;
				1:  b = {b[7:4], dlen[11:8]};
				2:  b = dlen[7:0];
				4:  b = mdl;
				6:  b = blk[15:8];
				7:  b = blk[7:0];
				12: b = grp;
				14: b = ver[15:8];
				15: b = ver[7:0];
				28: b = nblk[15:8];
				29: b = nblk[7:0];
				default: ;
			endcase
			sect_buf.push_back(b);
		end
		for (i = 0; i < plen; i++) sect_buf.push_back(8'($urandom));
	endtask

	// append the CRC so the residue over the whole section is zero
	task automatic seal_section();
		logic [31:0] c;
		int          i;
		c = 32'hFFFF_FFFF;
		for (i = 0; i < sect_buf.size(); i++) c = crc_next(c, sect_buf[i]);
		sect_buf.push_back(c[31:24]);
		sect_buf.push_back(c[23:16]);
		sect_buf.push_back(c[15:8]);
		sect_buf.push_back(c[7:0]);
	endtask

	task automatic send_good(logic [15:0] blk, logic [15:0] nblk, int plen);
		build_section(reg_group, reg_module, reg_version, blk, nblk, plen);
		seal_section();
		send_section();
	endtask

	// blocks below the limit that are (or are not) stored yet
	task automatic list_blocks(bit stored);
		int i;
		pick_pool.delete();
		for (i = 0; i < dl_limit; i++)
			if (dl_have[i] == stored) pick_pool.push_back(i);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_GROUP:   reg_group = val[7:0];
			CFG_MODULE:  reg_module = val[7:0];
			CFG_VERSION: reg_version = val;
			default: ;
		endcase
	endtask

	task automatic write_all(logic [7:0] grp, logic [7:0] mdl, logic [15:0] ver);
		write_reg(CFG_GROUP, {8'h0, grp});
		write_reg(CFG_MODULE, {8'h0, mdl});
		write_reg(CFG_VERSION, ver);
		cfg_sets++;
	endtask

	// drop valid, wait for all results, then let the pipeline drain
	task automatic settle();
		@(negedge clk);
		section_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// result side: random stall runs, or a long hold when asked for
	initial begin
		int left;
		left = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else if (left > 0)
				left--;
			else if (calm) begin
				result_stall <= 1'b0;
				left = 4;
			end else begin
				result_stall <= ($urandom_range(0, 3) == 0);
				left = idle_len();
			end
		end
	end

	// ------------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------------

	task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (verdict_q.size() == 0) begin
				$error("result transaction with no section pending (status %0d)", status);
				err_cnt++;
			end else begin
				want = verdict_q.pop_front();
				cmp_field("status", want.st, status);
				cmp_field("block_number", want.blk, block_number);
				cmp_field("buffer_offset", want.off, buffer_offset);
				cmp_field("payload_bytes", want.plen, payload_bytes);
				cmp_field("blocks_done", want.done, blocks_done);
				cmp_field("total_size", want.size, total_size);
				checked_cnt++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// registers at the top of their ranges, written during the bitmap sweep
	task automatic test_config_after_reset();
		write_all(8'hFF, 8'hFF, 16'hFFFF);
	endtask

	// sections that must be dropped before any allocation
	task automatic test_bad_sections();
		int i;
		// single byte, and one byte short of the minimum
		sect_buf.delete();
		sect_buf.push_back(TABLE_ID);
		send_section();
		build_section(reg_group, reg_module, reg_version, 0, 8, 0);
		void'(sect_buf.pop_back());
		seal_section();
		send_section();
		// wrong table id
		build_section(reg_group, reg_module, reg_version, 0, 8, 4);
		sect_buf[0] = ~TABLE_ID;
		seal_section();
		send_section();
		// declared length off by one
		build_section(reg_group, reg_module, reg_version, 0, 8, 4);
		sect_buf[2] = sect_buf[2] + 8'd1;
		seal_section();
		send_section();
		// corrupted CRC
		build_section(reg_group, reg_module, reg_version, 0, 8, 4);
		seal_section();
		sect_buf[sect_buf.size() - 1] ^= 8'h01;
		send_section();
		// foreign group and module, then a stale version
		build_section(reg_group ^ 8'h01, reg_module, reg_version, 0, 8, 4);
		seal_section();
		send_section();
		build_section(reg_group, reg_module ^ 8'h80, reg_version, 0, 8, 4);
		seal_section();
		send_section();
		build_section(reg_group, reg_module, reg_version ^ 16'h8001, 0, 8, 4);
		seal_section();
		send_section();
		// overlong: byte counter saturates, length cannot match
		calm = 1'b1;
		build_section(reg_group, reg_module, reg_version, 0, 8, 4);
		for (i = 0; i < 8200 - 34; i++) sect_buf.push_back(8'($urandom));
		seal_section();
		send_section();
		calm = 1'b0;
	endtask

	// first accepted section fixes the block limit
	task automatic test_allocation();
		dl_target = $urandom_range(24, 40);
		send_good(0, MAX_BLOCKS + 1, 5);
		send_good(0, 16'hFFFF, 5);
		// exactly minimum size: allocates, then dropped for an empty payload
		send_good(0, dl_target, 0);
	endtask

	task automatic test_block_bookkeeping();
		send_good(0, dl_target, 1);
		calm = 1'b1;
		send_good(dl_target - 1, dl_target, 4064);
		calm = 1'b0;
		send_good(0, dl_target, 7);          // duplicate
		send_good(5, 5, 3);                  // id not below the section's total
		send_good(1, dl_target + 1, 3);      // total above the limit
		send_good(1, 2, 9);                  // smaller total is fine
		send_good(2, dl_target, 0);          // empty payload
		settle();
		write_all(8'h00, 8'h00, 16'h0000);
	endtask

	// hold the result side while short sections keep arriving
	task automatic test_output_hold();
		int i;
		int n;
		int k;
		settle();
		calm = 1'b1;
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		for (i = 0; i < 60; i++) begin
			if (i == 30) begin
				list_blocks(1'b0);
				send_good(pick_pool[0], dl_target, $urandom_range(1, 6));
			end
			n = $urandom_range(1, 4);
			sect_buf.delete();
			for (k = 0; k < n; k++) sect_buf.push_back(8'($urandom));
			send_section();
		end
		calm = 1'b0;
		settle();
	endtask

	// mostly well-formed sections for open blocks, the rest broken or stray
	task automatic test_random_download();
		int          s;
		int          n;
		int          k;
		int          plen;
		logic [7:0]  grp;
		logic [7:0]  mdl;
		logic [15:0] ver;
		logic [15:0] blk;
		logic [15:0] nblk;
		s = 0;
		while (s < 70 || (dl_stored != dl_limit && s < 200)) begin
			if (s % 20 == 19) begin
				settle();
				write_all(8'($urandom), 8'($urandom), 16'($urandom));
			end
			if ($urandom_range(0, 7) == 0) calm = !calm;
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 400) : $urandom_range(1, 24);
			grp = reg_group;
			mdl = reg_module;
			ver = reg_version;
			// next open block; the last one is kept back until late
			list_blocks(1'b0);
			if (pick_pool.size() > 1 || (pick_pool.size() == 1 && s >= 50))
				blk = 16'(pick_pool[$urandom_range(0, pick_pool.size() - 1)]);
			else
				blk = 16'h0;
			nblk = ($urandom_range(0, 2) != 0) ? 16'(dl_limit) :
				16'($urandom_range(blk + 1, dl_limit));
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 19) == 0) plen = 0;
				build_section(grp, mdl, ver, blk, nblk, plen);
				seal_section();
			end else begin
				k = $urandom_range(0, 7);
				case (k)
					2: grp = grp ^ 8'($urandom_range(1, 255));
					3: mdl = mdl ^ 8'($urandom_range(1, 255));
					4: ver = ver ^ 16'($urandom_range(1, 65535));
					5: begin
						list_blocks(1'b1);
						if (pick_pool.size() > 0)
							blk = 16'(pick_pool[$urandom_range(0, pick_pool.size() - 1)]);
					end
					6: begin
						if ($urandom_range(0, 1)) begin
							nblk = 16'(dl_limit + $urandom_range(1, 300));
						end else begin
							nblk = 16'($urandom_range(1, dl_limit));
							blk  = nblk + 16'($urandom_range(0, 3));
						end
					end
					default: ;
				endcase
				build_section(grp, mdl, ver, blk, nblk, plen);
				if (k == 7) begin
					if ($urandom_range(0, 1))
						sect_buf[0] = TABLE_ID ^ 8'($urandom_range(1, 255));
					else
						sect_buf[2] = sect_buf[2] ^ 8'($urandom_range(1, 255));
				end
				seal_section();
				if (k == 1) begin
					n = $urandom_range(0, sect_buf.size() - 1);
					sect_buf[n] = sect_buf[n] ^ 8'($urandom_range(1, 255));
				end
				if (k == 0) begin
					// runt, sometimes starting like a real section
					n = $urandom_range(1, 33);
					sect_buf.delete();
					for (k = 0; k < n; k++) sect_buf.push_back(8'($urandom));
					if ($urandom_range(0, 1)) sect_buf[0] = TABLE_ID;
				end
			end
			send_section();
			s++;
		end
		calm = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = CFG_GROUP;
		cfg_data      = '0;
		section_valid = 1'b0;
		section_byte  = '0;
		last_byte     = 1'b0;
		reset_model();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_config_after_reset();
		test_bad_sections();
		test_allocation();
		test_block_bookkeeping();
		test_output_hold();
		test_random_download();

		settle();
		repeat (20) @(posedge clk);

		$display("Checked %0d results from %0d sections (%0d bytes); %0d of %0d blocks stored.",
			checked_cnt, sect_cnt, byte_cnt, dl_stored, dl_limit);
		$display("Covered rejects, allocation, duplicates, a %0d-cycle output hold, %0d register sets.",
			HOLD_CYCLES, cfg_sets);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#8_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
